// ----- src/ipf_pkg.sv -----
// ipf_pkg: shared types, character codes and helper functions for the
// ip address text formatter. No dependencies; used by every module.
package ipf_pkg;

  // input and result payloads
  typedef struct packed {
    logic [1:0]  family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } in_item_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } out_item_t;

  // family codes
  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  // ascii codes
  localparam logic [6:0] CH_COLON = 7'h3a;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_LOW_A = 7'h61;

  // decimal digit positions within one byte
  localparam logic [1:0] DIG_HUND = 2'd0;
  localparam logic [1:0] DIG_TENS = 2'd1;
  localparam logic [1:0] DIG_ONES = 2'd2;

  // last index of the word "invalid"
  localparam logic [2:0] INV_LAST = 3'd6;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GRP,
    ST_HEX,
    ST_DEC,
    ST_DOT,
    ST_INV,
    ST_FLUSH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic dec_init;
    logic dec_emit;
    logic dot_emit;
    logic hex_init;
    logic hex_emit;
    logic colon_emit;
    logic run_jump;
    logic inv_init;
    logic inv_emit;
    logic flush;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] family;
    logic       grp_end;
    logic       tail_colon;
    logic       run_start;
    logic       grp_first;
    logic       embed_here;
    logic       dig_last;
    logic       byte_last;
    logic       nib_last;
    logic       inv_last;
  } stat_t;

  // longest zero-group run
  typedef struct packed {
    logic       on;
    logic [2:0] base;
    logic [3:0] len;
  } run_t;

  // longest run of zero groups, earliest wins a tie, runs of one dropped
  function automatic run_t find_run(input logic [7:0] zero);
    run_t best;
    run_t cur;
    logic z;
    best = '0;
    cur  = '0;
    for (int i = 0; i <= 8; i++) begin
      z = (i < 8) ? zero[i[2:0]] : 1'b0;
      if (z) begin
        if (!cur.on) begin
          cur.on   = 1'b1;
          cur.base = 3'(i);
          cur.len  = 4'd1;
        end else begin
          cur.len = cur.len + 4'd1;
        end
      end else if (cur.on) begin
        if (!best.on || cur.len > best.len) begin
          best = cur;
        end
        cur.on = 1'b0;
      end
    end
    if (best.on && best.len < 4'd2) begin
      best.on = 1'b0;
    end
    return best;
  endfunction

  // index of the first nibble written for a group (leading zeros dropped)
  function automatic logic [1:0] hex_start(input logic [15:0] w);
    if (w[15:12] != 4'd0) return 2'd3;
    else if (w[11:8] != 4'd0) return 2'd2;
    else if (w[7:4] != 4'd0) return 2'd1;
    else return 2'd0;
  endfunction

  // lowercase hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {3'b000, nib};
    else return CH_LOW_A + {3'b000, nib - 4'd10};
  endfunction

  // first decimal digit position written for a byte
  function automatic logic [1:0] dec_start(input logic [7:0] v);
    if (v >= 8'd100) return DIG_HUND;
    else if (v >= 8'd10) return DIG_TENS;
    else return DIG_ONES;
  endfunction

  // decimal digit of a byte, tens by multiply with a reciprocal
  function automatic logic [6:0] dec_char(input logic [7:0] v, input logic [1:0] pos);
    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    logic [3:0]  d;
    hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = v - 8'(hund) * 8'd100;
    prod = 15'(rem[6:0]) * 15'd205;
    tens = prod[14:11];
    ones = rem - 8'(tens) * 8'd10;
    case (pos)
      DIG_HUND: d = {2'b00, hund};
      DIG_TENS: d = tens;
      default:  d = ones[3:0];
    endcase
    return CH_ZERO + {3'b000, d};
  endfunction

  // characters of the word "invalid"
  function automatic logic [6:0] inv_char(input logic [2:0] idx);
    case (idx)
      3'd0:    return 7'h69;
      3'd1:    return 7'h6e;
      3'd2:    return 7'h76;
      3'd3:    return 7'h61;
      3'd4:    return 7'h6c;
      3'd5:    return 7'h69;
      default: return 7'h64;
    endcase
  endfunction

endpackage

// ----- src/ip_address_text_formatter_core.sv -----
// ip_address_text_formatter_core: top level of the address text formatter.
// Depends on ipf_pkg, ipf_ctrl and ipf_datapath.
// busy stays high while an item is formatted. Characters pass through a holding stage,
// so each one appears once the next character or the end of the item is known;
// the last one appears in the first idle cycle, where the next item may start.
// Synchronous active-low reset returns the sequencer to idle with no output.
module ip_address_text_formatter_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ipf_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ipf_pkg::out_item_t out_item
);
  import ipf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  ipf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // registers and character generation
  ipf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- src/ipf_ctrl.sv -----
// ipf_ctrl: sequencing state machine of the formatter.
// Depends on ipf_pkg (state_t, cmd_t, stat_t, family codes).
module ipf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  ipf_pkg::stat_t stat,
  output logic           busy,
  output ipf_pkg::cmd_t  cmd
);
  import ipf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.family == FAM_V4) state_nxt = ST_DEC;
        else if (stat.family == FAM_V6) state_nxt = ST_GRP;
        else state_nxt = ST_INV;
      end
      ST_GRP: begin
        if (stat.grp_end) state_nxt = ST_FLUSH;
        else if (stat.run_start) state_nxt = ST_GRP;
        else if (stat.grp_first) state_nxt = ST_HEX;
        else if (stat.embed_here) state_nxt = ST_DEC;
        else state_nxt = ST_HEX;
      end
      ST_HEX: begin
        if (stat.nib_last) state_nxt = ST_GRP;
      end
      ST_DEC: begin
        if (stat.dig_last) state_nxt = stat.byte_last ? ST_FLUSH : ST_DOT;
      end
      ST_DOT: begin
        state_nxt = ST_DEC;
      end
      ST_INV: begin
        if (stat.inv_last) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_SCAN: begin
        if (stat.family == FAM_V4) cmd.dec_init = 1'b1;
        else if (stat.family == FAM_V6) cmd.scan = 1'b1;
        else cmd.inv_init = 1'b1;
      end
      ST_GRP: begin
        if (stat.grp_end) begin
          cmd.colon_emit = stat.tail_colon;
        end else if (stat.run_start) begin
          cmd.colon_emit = 1'b1;
          cmd.run_jump   = 1'b1;
        end else if (stat.grp_first) begin
          cmd.hex_init = 1'b1;
        end else begin
          cmd.colon_emit = 1'b1;
          cmd.dec_init   = stat.embed_here;
          cmd.hex_init   = !stat.embed_here;
        end
      end
      ST_HEX: begin
        cmd.hex_emit = 1'b1;
      end
      ST_DEC: begin
        cmd.dec_emit = 1'b1;
      end
      ST_DOT: begin
        cmd.dot_emit = 1'b1;
      end
      ST_INV: begin
        cmd.inv_emit = 1'b1;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- src/ipf_datapath.sv -----
// ipf_datapath: address registers, zero-run finder, digit counters and the
// one-character holding stage in front of the result register. Depends on ipf_pkg.
module ipf_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ipf_pkg::in_item_t  in_item,
  input  ipf_pkg::cmd_t      cmd,
  output ipf_pkg::stat_t     stat,
  output logic               out_valid,
  output ipf_pkg::out_item_t out_item
);
  import ipf_pkg::*;

  logic [127:0] addr_r;
  logic [1:0]   fam_r;
  logic [31:0]  word_r;
  run_t         run_r;
  logic         embed_r;
  logic [3:0]   grp_r;
  logic [1:0]   nib_r;
  logic [1:0]   byte_r;
  logic [1:0]   dig_r;
  logic [2:0]   inv_r;
  logic [6:0]   pend_r;
  logic         pend_vld_r;
  logic         out_vld_r;
  out_item_t    out_r;

  logic [15:0]  cur_grp;
  logic [7:0]   zero;
  run_t         run_nxt;
  logic [7:0]   cur_byte;
  logic [1:0]   byte_nxt;
  logic [7:0]   next_byte;
  logic [3:0]   run_end;
  logic         gen_vld;
  logic [6:0]   gen_char;

  // group and byte selection
  assign cur_grp   = addr_r[{~grp_r[2:0], 4'b0000} +: 16];
  assign cur_byte  = word_r[{~byte_r, 3'b000} +: 8];
  assign byte_nxt  = byte_r + 2'd1;
  assign next_byte = word_r[{~byte_nxt, 3'b000} +: 8];
  assign run_end   = {1'b0, run_r.base} + run_r.len;

  // zero groups and the longest run
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      zero[i] = (addr_r[(7 - i) * 16 +: 16] == 16'h0000);
    end
    run_nxt = find_run(zero);
  end

  // item registers and counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= {in_item.addr_high, in_item.addr_low};
      fam_r  <= in_item.family;
      word_r <= (in_item.family == FAM_V4) ? in_item.addr_high[63:32]
                                            : in_item.addr_low[31:0];
    end
    if (cmd.scan) begin
      run_r   <= run_nxt;
      embed_r <= run_nxt.on && (run_nxt.base == 3'd0) &&
                 ((run_nxt.len == 4'd6) ||
                  ((run_nxt.len == 4'd5) && (addr_r[47:32] == 16'hffff)));
      grp_r   <= 4'd0;
    end else if (cmd.run_jump) begin
      grp_r <= run_end;
    end else if (cmd.hex_emit && (nib_r == 2'd0)) begin
      grp_r <= grp_r + 4'd1;
    end
    if (cmd.hex_init) begin
      nib_r <= hex_start(cur_grp);
    end else if (cmd.hex_emit) begin
      nib_r <= nib_r - 2'd1;
    end
    if (cmd.dec_init) begin
      byte_r <= 2'd0;
      dig_r  <= dec_start(word_r[31:24]);
    end else if (cmd.dot_emit) begin
      byte_r <= byte_nxt;
      dig_r  <= dec_start(next_byte);
    end else if (cmd.dec_emit) begin
      dig_r <= dig_r + 2'd1;
    end
    if (cmd.inv_init) begin
      inv_r <= 3'd0;
    end else if (cmd.inv_emit) begin
      inv_r <= inv_r + 3'd1;
    end
  end

  // character generator
  always_comb begin
    gen_vld = cmd.colon_emit | cmd.dot_emit | cmd.dec_emit | cmd.hex_emit | cmd.inv_emit;
    if (cmd.colon_emit) gen_char = CH_COLON;
    else if (cmd.dot_emit) gen_char = CH_DOT;
    else if (cmd.dec_emit) gen_char = dec_char(cur_byte, dig_r);
    else if (cmd.hex_emit) gen_char = hex_char(cur_grp[{nib_r, 2'b00} +: 4]);
    else gen_char = inv_char(inv_r);
  end

  // holding stage: a character leaves once the next one or the end is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= (gen_vld && pend_vld_r) || cmd.flush;
      if (cmd.flush) pend_vld_r <= 1'b0;
      else if (gen_vld) pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_vld || cmd.flush) begin
      out_r.text_char <= pend_r;
      out_r.last_char <= cmd.flush;
    end
    if (gen_vld) begin
      pend_r <= gen_char;
    end
  end

  // status to the controller
  always_comb begin
    stat.family     = fam_r;
    stat.grp_end    = grp_r[3];
    stat.tail_colon = run_r.on && (run_end == 4'd8);
    stat.run_start  = run_r.on && (grp_r == {1'b0, run_r.base});
    stat.grp_first  = (grp_r == 4'd0);
    stat.embed_here = embed_r && (grp_r == 4'd6);
    stat.dig_last   = (dig_r == DIG_ONES);
    stat.byte_last  = (byte_r == 2'd3);
    stat.nib_last   = (nib_r == 2'd0);
    stat.inv_last   = (inv_r == INV_LAST);
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

// ----- src/ipf_checker.sv -----
// ipf_checker: port-level checks of the formatter, bound to the top level.
// Depends on ipf_pkg and ip_address_text_formatter_core.
module ipf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input ipf_pkg::out_item_t out_item
);
  import ipf_pkg::*;

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after accept");

  // end of an item shows the final character
  a_end_shows_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_item.last_char)
    else $error("item ended without final character");

  // final character only once the block is free again
  a_last_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_char |-> !busy)
    else $error("final character while busy");

  // characters come only from an item in progress
  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("character without an item");

endmodule

bind ip_address_text_formatter_core ipf_checker u_ipf_checker (.*);

// ----- dv/tb_ip_address_text_formatter_core.sv -----
// tb_ip_address_text_formatter_core: self-checking bench for the address text formatter.
// Depends on ipf_pkg and ip_address_text_formatter_core; a built-in text predictor
// checks every character strobe against the expected ipv4 / ipv6 / invalid text.
`timescale 1ns / 1ps

module tb_ip_address_text_formatter_core;
  import ipf_pkg::*;

  localparam logic [1:0] FAM_UNKNOWN = 2'd2;
  localparam logic [1:0] FAM_SPARE   = 2'd3;
  localparam int         TEXT_LIMIT  = 39;
  localparam int         RANDOM_ITEMS = 207;
  localparam string      INVALID_TEXT = "invalid";

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  in_item_t   pending_addrs [$];
  out_item_t  chars_due [$];
  logic [6:0] text_buf [$];
  int         bad_chars = 0;
  int         issued = 0;
  int         total_items = 0;
  logic       took = 1'b0;
  int         gap_pct [4] = '{0, 71, 0, 10};

  ip_address_text_formatter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // text predictor
  function automatic void put_ch(logic [6:0] c);
    if (text_buf.size() < TEXT_LIMIT) text_buf.push_back(c);
  endfunction

  function automatic void put_byte_dec(logic [7:0] v);
    int u;
    u = v;
    if (u >= 100) put_ch(CH_ZERO + 7'(u / 100));
    if (u >= 10) put_ch(CH_ZERO + 7'((u / 10) % 10));
    put_ch(CH_ZERO + 7'(u % 10));
  endfunction

  function automatic void put_dotted(logic [31:0] a);
    put_byte_dec(a[31:24]);
    put_ch(CH_DOT);
    put_byte_dec(a[23:16]);
    put_ch(CH_DOT);
    put_byte_dec(a[15:8]);
    put_ch(CH_DOT);
    put_byte_dec(a[7:0]);
  endfunction

  function automatic void put_group_hex(logic [15:0] w);
    logic       started;
    logic [3:0] nib;
    started = 1'b0;
    for (int s = 3; s >= 0; s--) begin
      nib = w[4*s +: 4];
      if (nib != 4'd0 || started || s == 0) begin
        put_ch(nib < 4'd10 ? CH_ZERO + 7'(nib) : CH_LOW_A + 7'(nib - 4'd10));
        started = 1'b1;
      end
    end
  endfunction

  function automatic void put_v6(logic [63:0] hi, logic [63:0] lo);
    logic [15:0] grp [8];
    int          run_at, run_len, cur_at, cur_len;
    logic        zero;
    for (int i = 0; i < 4; i++) begin
      grp[i]     = hi[63 - 16*i -: 16];
      grp[i + 4] = lo[63 - 16*i -: 16];
    end
    // longest zero run, earliest wins on a tie
    run_at = -1; run_len = 0; cur_at = -1; cur_len = 0;
    for (int i = 0; i <= 8; i++) begin
      zero = (i < 8) && (grp[i] == 16'h0);
      if (zero) begin
        if (cur_at < 0) begin
          cur_at = i;
          cur_len = 1;
        end else begin
          cur_len++;
        end
      end else if (cur_at >= 0) begin
        if (run_at < 0 || cur_len > run_len) begin
          run_at = cur_at;
          run_len = cur_len;
        end
        cur_at = -1;
      end
    end
    if (run_at >= 0 && run_len < 2) run_at = -1;
    // groups, with the run folded to a double colon
    for (int i = 0; i < 8; i++) begin
      if (run_at >= 0 && i >= run_at && i < run_at + run_len) begin
        if (i == run_at) put_ch(CH_COLON);
        continue;
      end
      if (i != 0) put_ch(CH_COLON);
      if (i == 6 && run_at == 0 &&
          (run_len == 6 || (run_len == 5 && grp[5] == 16'hffff))) begin
        put_dotted(lo[31:0]);
        return;
      end
      put_group_hex(grp[i]);
    end
    if (run_at >= 0 && run_at + run_len == 8) put_ch(CH_COLON);
  endfunction

  function automatic void predict_text(in_item_t it);
    out_item_t ch;
    text_buf.delete();
    if (it.family == FAM_V4) begin
      put_dotted(it.addr_high[63:32]);
    end else if (it.family == FAM_V6) begin
      put_v6(it.addr_high, it.addr_low);
    end else begin
      for (int k = 0; k < INVALID_TEXT.len(); k++) put_ch(7'(INVALID_TEXT[k]));
    end
    for (int k = 0; k < text_buf.size(); k++) begin
      ch.text_char = text_buf[k];
      ch.last_char = (k == text_buf.size() - 1);
      chars_due.push_back(ch);
    end
  endfunction

  // stimulus builders
  function automatic void queue_addr(logic [1:0] fam, logic [63:0] hi, logic [63:0] lo);
    in_item_t it;
    it.family = fam;
    it.addr_high = hi;
    it.addr_low = lo;
    pending_addrs.push_back(it);
  endfunction

  function automatic logic [15:0] pick_group();
    case ($urandom_range(5))
      0, 1:    return 16'h0;
      2:       return 16'($urandom_range(15));
      3:       return 16'($urandom_range(16'h0fff));
      4:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_random_addr();
    logic [127:0] addr;
    int           kind;
    addr = {$urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(99);
    if (kind < 15) begin
      queue_addr(FAM_V4, addr[127:64], addr[63:0]);
    end else if (kind < 25) begin
      queue_addr(2'($urandom_range(FAM_UNKNOWN, FAM_SPARE)), addr[127:64], addr[63:0]);
    end else if (kind < 35) begin
      // ::a.b.c.d
      queue_addr(FAM_V6, 64'h0, {32'h0, addr[31:0]});
    end else if (kind < 45) begin
      // ::ffff:a.b.c.d
      queue_addr(FAM_V6, 64'h0, {16'h0, 16'hffff, addr[31:0]});
    end else if (kind < 55) begin
      queue_addr(FAM_V6, addr[127:64], addr[63:0]);
    end else begin
      for (int g = 0; g < 8; g++) addr = {addr[111:0], pick_group()};
      queue_addr(FAM_V6, addr[127:64], addr[63:0]);
    end
  endfunction

  // driver: new item at the falling edge, held until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (pending_addrs.size() != 0 &&
                 $urandom_range(99) >= gap_pct[(issued * 4) / total_items]) begin
      in_item <= pending_addrs.pop_front();
      start   <= 1'b1;
      issued++;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: accept detection, prediction and character checks
  always @(posedge clk) begin
    out_item_t want;
    took = rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (chars_due.size() == 0) begin
        $display("%0t unexpected char: expected none, got char %h last %b",
                 $time, out_item.text_char, out_item.last_char);
        bad_chars++;
      end else begin
        want = chars_due.pop_front();
        if (out_item.text_char !== want.text_char || out_item.last_char !== want.last_char) begin
          $display("%0t mismatch: expected char %h last %b, got char %h last %b",
                   $time, want.text_char, want.last_char,
                   out_item.text_char, out_item.last_char);
          bad_chars++;
        end
      end
    end
    if (took) predict_text(in_item);
  end

  // main sequence
  initial begin
    int n;
    // directed: ipv4 extremes and ignored bits
    queue_addr(FAM_V4, 64'h0, 64'h0);
    queue_addr(FAM_V4, '1, '1);
    queue_addr(FAM_V4, {32'h010a64c8, $urandom}, {$urandom, $urandom});
    queue_addr(FAM_V4, 64'h0963c7fa_00000000, 64'h0);
    queue_addr(FAM_V4, 64'hff00090a_ffffffff, '1);
    // unknown families
    queue_addr(FAM_UNKNOWN, {$urandom, $urandom}, {$urandom, $urandom});
    queue_addr(FAM_SPARE, {$urandom, $urandom}, {$urandom, $urandom});
    // ipv6 all zero, all ones, loopback, run at the tail
    queue_addr(FAM_V6, 64'h0, 64'h0);
    queue_addr(FAM_V6, '1, '1);
    queue_addr(FAM_V6, 64'h0, 64'h1);
    queue_addr(FAM_V6, 64'h0001_0000_0000_0000, 64'h0);
    // embedded dotted forms and near misses
    queue_addr(FAM_V6, 64'h0, 64'h0000_ffff_0102_0304);
    queue_addr(FAM_V6, 64'h0, 64'h0000_0000_0102_0304);
    queue_addr(FAM_V6, 64'h0, 64'h0000_ffff_0000_0000);
    queue_addr(FAM_V6, 64'h0, 64'h0000_1234_5678_9abc);
    queue_addr(FAM_V6, 64'h0, 64'h0000_0000_0000_ffff);
    queue_addr(FAM_V6, 64'h0, 64'h0000_0000_c8ff_0a63);
    // single zero group, tie, later longer run, alternating zeros
    queue_addr(FAM_V6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007);
    queue_addr(FAM_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004);
    queue_addr(FAM_V6, 64'h0000_0000_0001_0000, 64'h0000_0000_0002_0003);
    queue_addr(FAM_V6, 64'h0000_00a0_0000_0b00, 64'h0000_c000_0000_000d);
    queue_addr(FAM_V6, 64'h2001_0db8_0000_0001, 64'h0001_0001_0000_0000);
    // longest text
    queue_addr(FAM_V6, 64'h1234_5678_9abc_def0, 64'hfedc_ba98_7654_3210);
    // random part
    for (n = 0; n < RANDOM_ITEMS; n++) queue_random_addr();
    total_items = pending_addrs.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain stimulus, then expectations, then a latency tail
    while (pending_addrs.size() != 0 || start) @(posedge clk);
    for (n = 0; n < 2000 && chars_due.size() != 0; n++) @(posedge clk);
    if (chars_due.size() != 0) begin
      $display("%0t missing chars: expected %0d more, got none", $time, chars_due.size());
      bad_chars++;
    end
    repeat (50) @(posedge clk);
    if (bad_chars == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
src/ipf_pkg.sv
src/ipf_ctrl.sv
src/ipf_datapath.sv
src/ip_address_text_formatter_core.sv
src/ipf_checker.sv
dv/tb_ip_address_text_formatter_core.sv
